// File: src/pse_pkg.sv
// ----------------------------------------------------------------------------
// pse_pkg: shared types and constants
// Holds the stack size, the token and status codes and the cell control type
// for the postfix stack evaluator.
// ----------------------------------------------------------------------------
`default_nettype none

package pse_pkg;

  localparam int STACK_DEPTH = 64;
  localparam int DEPTH_W     = $clog2(STACK_DEPTH + 1);
  localparam int DATA_W      = 32;

  localparam logic       ACT_PUSH  = 1'b0;
  localparam logic       ACT_OPER  = 1'b1;

  localparam logic [1:0] OP_ADD    = 2'd0;
  localparam logic [1:0] OP_SUB    = 2'd1;
  localparam logic [1:0] OP_MUL    = 2'd2;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_UNDER  = 2'd1;
  localparam logic [1:0] ST_OVER   = 2'd2;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctrl_t;

  typedef struct packed {
    logic              last;
    logic [1:0]        status;
    logic [6:0]        depth;
    logic [DATA_W-1:0] top;
  } result_t;

endpackage : pse_pkg

`default_nettype wire

// File: src/postfix_stack_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator: reverse Polish integer evaluator
// Channel  Dir  tdata (low bit up)                  tuser    tlast
// s_axis   in   operand_value[31:0] op_code[33:32]  action   last_token
// m_axis   out  top_value[31:0] stack_depth[38:32]  -        expression_done
//               status[40:39]
// One token per cycle while s_axis_tready is high; each result is registered in the output buffer.
// The stack is a shift row of cells; top and second entries feed the
// operator unit directly, so no token waits on another.
// Reset clears the depth and the output buffer; entries are never cleared.
// Two output registers absorb a stall; s_axis_tready drops once both hold.
// ----------------------------------------------------------------------------
`default_nettype none

module postfix_stack_evaluator
  import pse_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         s_axis_tvalid,
  output logic        s_axis_tready,
  input  wire  [39:0] s_axis_tdata,   // operand_value[31:0], op_code[33:32]
  input  wire         s_axis_tuser,   // action
  input  wire         s_axis_tlast,   // last_token
  output logic        m_axis_tvalid,
  input  wire         m_axis_tready,
  output logic [47:0] m_axis_tdata,   // top_value[31:0], stack_depth[38:32],
                                      // status[40:39]
  output logic        m_axis_tlast    // expression_done
);

  logic [DATA_W-1:0]  entries [STACK_DEPTH];
  logic [DEPTH_W-1:0] depth;
  logic [DEPTH_W-1:0] depth_next;
  logic               accept;
  logic               is_push;
  logic               over;
  logic               under;
  logic [DATA_W-1:0]  value;
  logic [1:0]         op_code;
  logic [DATA_W-1:0]  alu_result;
  logic [DATA_W-1:0]  top_next;
  cell_ctrl_t         ctrl;
  result_t            res;
  result_t            out_res;

  assign value   = s_axis_tdata[DATA_W-1:0];
  assign op_code = s_axis_tdata[DATA_W+1:DATA_W];
  assign accept  = s_axis_tvalid && s_axis_tready;
  assign is_push = (s_axis_tuser == ACT_PUSH);
  assign over    = is_push && (depth == DEPTH_W'(STACK_DEPTH));
  assign under   = !is_push && (depth < DEPTH_W'(2));

  assign ctrl.push = accept && is_push && !over;
  assign ctrl.pop  = accept && !is_push && !under;

  pse_alu u_alu (
    .op_code (op_code),
    .lower   (entries[1]),
    .upper   (entries[0]),
    .result  (alu_result)
  );

  pse_cell u_cell_top (
    .clk       (clk),
    .ctrl      (ctrl),
    .push_data (value),
    .pop_data  (alu_result),
    .entry     (entries[0])
  );

  for (genvar i = 1; i < STACK_DEPTH; i++) begin : g_cell
    pse_cell u_cell (
      .clk       (clk),
      .ctrl      (ctrl),
      .push_data (entries[i-1]),
      .pop_data  (entries[(i + 1 < STACK_DEPTH) ? i + 1 : i]),
      .entry     (entries[i])
    );
  end

  always_comb begin
    depth_next = depth;
    top_next   = entries[0];
    res.status = ST_OK;
    priority if (over) begin
      res.status = ST_OVER;
    end else if (under) begin
      res.status = ST_UNDER;
    end else if (is_push) begin
      depth_next = depth + DEPTH_W'(1);
      top_next   = value;
    end else begin
      depth_next = depth - DEPTH_W'(1);
      top_next   = alu_result;
    end
    res.top   = (depth_next == '0) ? '0 : top_next;
    res.depth = 7'(depth_next);
    res.last  = s_axis_tlast;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      depth <= '0;
    end else if (accept) begin
      depth <= s_axis_tlast ? '0 : depth_next;
    end
  end

  pse_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (accept),
    .in_ready  (s_axis_tready),
    .in_data   (res),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (out_res)
  );

  assign m_axis_tdata = {7'b0, out_res.status, out_res.depth, out_res.top};
  assign m_axis_tlast = out_res.last;

endmodule : postfix_stack_evaluator

`default_nettype wire

// File: src/pse_cell.sv
// ----------------------------------------------------------------------------
// pse_cell: one stack entry
// Loads the entry above it on a push and the entry below it on a pop; holds
// otherwise.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_cell
  import pse_pkg::*;
(
  input  wire               clk,
  input  cell_ctrl_t        ctrl,
  input  wire  [DATA_W-1:0] push_data,
  input  wire  [DATA_W-1:0] pop_data,
  output logic [DATA_W-1:0] entry
);

  always_ff @(posedge clk) begin
    if (ctrl.push) begin
      entry <= push_data;
    end else if (ctrl.pop) begin
      entry <= pop_data;
    end
  end

endmodule : pse_cell

`default_nettype wire

// File: src/pse_alu.sv
// ----------------------------------------------------------------------------
// pse_alu: operator unit
// Combines second-from-top and top with 32-bit wrap-around add, subtract or
// multiply; the unused code gives zero.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_alu
  import pse_pkg::*;
(
  input  wire  [1:0]        op_code,
  input  wire  [DATA_W-1:0] lower,
  input  wire  [DATA_W-1:0] upper,
  output logic [DATA_W-1:0] result
);

  always_comb begin
    unique case (op_code)
      OP_ADD:  result = lower + upper;
      OP_SUB:  result = lower - upper;
      OP_MUL:  result = lower * upper;
      default: result = '0;
    endcase
  end

endmodule : pse_alu

`default_nettype wire

// File: src/pse_skid.sv
// ----------------------------------------------------------------------------
// pse_skid: two-entry output buffer
// Holds results in an output register and a skid register so the input side
// can take one more token after the output side stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module pse_skid
  import pse_pkg::*;
(
  input  wire      clk,
  input  wire      rst,
  input  wire      in_valid,
  output logic     in_ready,
  input  result_t  in_data,
  output logic     out_valid,
  input  wire      out_ready,
  output result_t  out_data
);

  logic    skid_valid;
  result_t skid_data;
  logic    drain;

  assign in_ready = !skid_valid;
  assign drain    = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid  <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (drain) begin
        skid_valid <= 1'b0;
      end
    end else if (in_valid) begin
      if (out_valid && !out_ready) begin
        skid_valid <= 1'b1;
      end else begin
        out_valid <= 1'b1;
      end
    end else if (drain) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (drain) begin
        out_data <= skid_data;
      end
    end else if (in_valid) begin
      if (out_valid && !out_ready) begin
        skid_data <= in_data;
      end else begin
        out_data <= in_data;
      end
    end
  end

endmodule : pse_skid

`default_nettype wire

// File: test/postfix_stack_evaluator_test.sv
// ----------------------------------------------------------------------------
// postfix_stack_evaluator_test: token stream check of the postfix evaluator
// Drives reverse Polish token streams into the slave stream port and checks
// every result transfer against an in-bench stack model, field by field.
// Covers the arithmetic extremes, all operator codes, underflow, overflow
// on a full stack, the last-token clear, random idling on both sides and a
// long receiver hold-off that fills the output buffer.
// ----------------------------------------------------------------------------
module postfix_stack_evaluator_test;
  import pse_pkg::*;

  localparam logic [1:0] OP_UNUSED    = 2'd3;
  localparam int         LIMIT_CYCLES = 100000;
  localparam int         HOLD_CYCLES  = 200;
  localparam int         MAX_REPORTS  = 60;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [39:0] s_axis_tdata = '0;
  logic        s_axis_tuser = 1'b0;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;
  logic        m_axis_tlast;

  logic [DATA_W-1:0] model_stack [STACK_DEPTH];
  int                model_depth = 0;
  result_t           pending_results [$];

  int   error_count  = 0;
  int   tokens_sent  = 0;
  int   cycle_count  = 0;
  logic idle_on      = 1'b0;
  logic hold_request = 1'b0;

  postfix_stack_evaluator uut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .s_axis_tlast  (s_axis_tlast),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Verification failed");
      $finish;
    end
  end

  function automatic result_t evaluate_token(logic act, logic [DATA_W-1:0] val,
                                             logic [1:0] opc, logic lst);
    result_t           r;
    logic [DATA_W-1:0] lower;
    logic [DATA_W-1:0] upper;
    r.status = ST_OK;
    r.last   = lst;
    if (act == ACT_PUSH) begin
      if (model_depth >= STACK_DEPTH) begin
        r.status = ST_OVER;
      end else begin
        model_stack[model_depth] = val;
        model_depth++;
      end
    end else if (model_depth < 2) begin
      r.status = ST_UNDER;
    end else begin
      upper = model_stack[model_depth-1];
      lower = model_stack[model_depth-2];
      model_depth--;
      case (opc)
        OP_ADD:  model_stack[model_depth-1] = lower + upper;
        OP_SUB:  model_stack[model_depth-1] = lower - upper;
        OP_MUL:  model_stack[model_depth-1] = lower * upper;
        default: model_stack[model_depth-1] = '0;
      endcase
    end
    r.top   = (model_depth > 0) ? model_stack[model_depth-1] : '0;
    r.depth = model_depth[6:0];
    if (lst) model_depth = 0;
    return r;
  endfunction

  function automatic logic [DATA_W-1:0] pick_operand();
    case ($urandom_range(0, 15))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return 32'hFFFF_FFFF;
      3:       return 32'h0000_0000;
      4:       return 32'h0000_0001;
      5:       return $urandom_range(0, 15);
      default: return $urandom;
    endcase
  endfunction

  // Call at a rising edge; returns at the edge where the transfer happens.
  task automatic send_token(logic act, logic [DATA_W-1:0] val, logic [1:0] opc,
                            logic lst);
    logic    ready_seen;
    result_t expected;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= act;
    s_axis_tlast  <= lst;
    s_axis_tdata  <= {6'b0, opc, val};
    do begin
      @(negedge clk);
      ready_seen = s_axis_tready;
      @(posedge clk);
    end while (!ready_seen);
    expected        = evaluate_token(act, val, opc, lst);
    pending_results = {pending_results, expected};
    tokens_sent++;
  endtask

  task automatic send_expression(int operand_count, int noise_pct);
    int   pushed;
    logic finished;
    pushed   = 0;
    finished = 1'b0;
    while (!finished) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        send_token(1'($urandom_range(0, 1)), $urandom, 2'($urandom_range(0, 3)),
                   $urandom_range(0, 15) == 0);
      end else if (pushed >= operand_count && model_depth <= 2) begin
        if (model_depth == 2)
          send_token(ACT_OPER, $urandom, 2'($urandom_range(0, 2)), 1'b1);
        else
          send_token(ACT_PUSH, pick_operand(), 2'($urandom_range(0, 3)), 1'b1);
        finished = 1'b1;
      end else if (pushed < operand_count && (model_depth < 2 || $urandom_range(0, 1))) begin
        send_token(ACT_PUSH, pick_operand(), 2'($urandom_range(0, 3)), 1'b0);
        pushed++;
      end else begin
        send_token(ACT_OPER, $urandom, 2'($urandom_range(0, 2)), 1'b0);
      end
    end
  endtask

  task automatic report_field(string field, logic [DATA_W-1:0] expected,
                              logic [DATA_W-1:0] actual);
    error_count++;
    if (error_count <= MAX_REPORTS)
      $display("%0t: %s mismatch, expected %h actual %h", $time, field, expected, actual);
  endtask

  initial begin
    result_t exp_r;
    forever begin
      @(negedge clk);
      if (!rst && m_axis_tvalid && m_axis_tready) begin
        if (pending_results.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("%0t: unexpected result, expected none actual %h", $time, m_axis_tdata);
        end else begin
          exp_r = pending_results.pop_front();
          if (m_axis_tdata[31:0] !== exp_r.top)
            report_field("top_value", exp_r.top, m_axis_tdata[31:0]);
          if (m_axis_tdata[38:32] !== exp_r.depth)
            report_field("stack_depth", DATA_W'(exp_r.depth),
                         DATA_W'(m_axis_tdata[38:32]));
          if (m_axis_tdata[40:39] !== exp_r.status)
            report_field("status", DATA_W'(exp_r.status), DATA_W'(m_axis_tdata[40:39]));
          if (m_axis_tlast !== exp_r.last)
            report_field("expression_done", DATA_W'(exp_r.last), DATA_W'(m_axis_tlast));
        end
      end
    end
  end

  initial begin
    forever begin
      @(posedge clk);
      if (hold_request) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_request = 1'b0;
        m_axis_tready <= 1'b1;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        m_axis_tready <= 1'b0;
        repeat ($urandom_range(1, 12)) @(posedge clk);
        m_axis_tready <= 1'b1;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  task automatic test_directed();
    send_token(ACT_OPER, 32'h0,         OP_ADD,    1'b0);
    send_token(ACT_PUSH, 32'h7FFF_FFFF, OP_ADD,    1'b0);
    send_token(ACT_OPER, 32'h0,         OP_SUB,    1'b0);
    send_token(ACT_PUSH, 32'h0000_0001, OP_ADD,    1'b0);
    send_token(ACT_OPER, 32'h0,         OP_ADD,    1'b0);
    send_token(ACT_PUSH, 32'h8000_0000, OP_ADD,    1'b0);
    send_token(ACT_OPER, 32'h0,         OP_SUB,    1'b0);
    send_token(ACT_PUSH, 32'h8000_0000, OP_MUL,    1'b0);
    send_token(ACT_PUSH, 32'hFFFF_FFFF, OP_SUB,    1'b0);
    send_token(ACT_OPER, 32'h0,         OP_MUL,    1'b0);
    send_token(ACT_PUSH, 32'h0000_0002, OP_ADD,    1'b0);
    send_token(ACT_PUSH, 32'h0000_0009, OP_ADD,    1'b0);
    send_token(ACT_OPER, 32'h0,         OP_SUB,    1'b0);
    send_token(ACT_PUSH, 32'hFFFF_FFFB, OP_ADD,    1'b0);
    send_token(ACT_OPER, 32'hFFFF_FFFF, OP_MUL,    1'b0);
    send_token(ACT_PUSH, 32'h1234_5678, OP_UNUSED, 1'b0);
    send_token(ACT_OPER, 32'hFFFF_FFFF, OP_UNUSED, 1'b0);
    send_token(ACT_OPER, 32'h0,         OP_ADD,    1'b1);
    send_token(ACT_OPER, 32'h0,         OP_MUL,    1'b1);
    send_token(ACT_PUSH, 32'hFFFF_FFFF, OP_UNUSED, 1'b1);
    send_token(ACT_PUSH, 32'h0000_0000, OP_ADD,    1'b0);
    send_token(ACT_OPER, 32'h0,         OP_ADD,    1'b1);
  endtask

  task automatic test_overflow();
    while (model_depth < STACK_DEPTH)
      send_token(ACT_PUSH, pick_operand(), 2'($urandom_range(0, 3)), 1'b0);
    send_token(ACT_PUSH, 32'h7FFF_FFFF, OP_ADD, 1'b0);
    send_token(ACT_PUSH, 32'h8000_0000, OP_UNUSED, 1'b0);
    send_token(ACT_OPER, $urandom, OP_SUB, 1'b0);
    send_token(ACT_PUSH, pick_operand(), OP_MUL, 1'b0);
    send_token(ACT_PUSH, 32'hFFFF_FFFF, OP_ADD, 1'b1);
    send_token(ACT_PUSH, pick_operand(), OP_ADD, 1'b0);
    send_token(ACT_OPER, $urandom, OP_MUL, 1'b1);
  endtask

  task automatic test_backpressure();
    hold_request = 1'b1;
    repeat (4) send_expression($urandom_range(6, 12), 0);
  endtask

  task automatic test_random();
    int start_count;
    start_count = tokens_sent;
    idle_on = 1'b1;
    while (tokens_sent - start_count < 280) begin
      if ($urandom_range(0, 9) == 0) send_expression($urandom_range(20, 66), 8);
      else                           send_expression($urandom_range(1, 8), 8);
    end
  endtask

  task automatic test_full_rate();
    idle_on = 1'b0;
    repeat (6) send_expression($urandom_range(1, 10), 5);
  endtask

  initial begin
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_overflow();
    test_backpressure();
    test_random();
    test_full_rate();
    s_axis_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
src/pse_pkg.sv
src/pse_cell.sv
src/pse_alu.sv
src/pse_skid.sv
src/postfix_stack_evaluator.sv
test/postfix_stack_evaluator_test.sv
